[src/jesl_pkg.sv]
// Package with payload types, status codes and scan phase codes for the JPEG Exif locator
`default_nettype none
package jesl_pkg;

  localparam int MaxMarkerReads = 7;
  localparam int PositionBits   = 32;

  // input beat: one file byte plus framing flags
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_file;
  } item_t;

  // result beat: scan outcome
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] exif_location;
    logic [15:0] segment_length;
  } result_t;

  // outcome codes
  localparam logic [2:0] ST_EXIF      = 3'd0;
  localparam logic [2:0] ST_NOSOI     = 3'd1;
  localparam logic [2:0] ST_SOS       = 3'd2;
  localparam logic [2:0] ST_EOI       = 3'd3;
  localparam logic [2:0] ST_NOTEXIF   = 3'd4;
  localparam logic [2:0] ST_FILL      = 3'd5;
  localparam logic [2:0] ST_BADLEN    = 3'd6;
  localparam logic [2:0] ST_PREMATURE = 3'd7;

  // scan phases
  localparam logic [2:0] PH_SOI0 = 3'd0;
  localparam logic [2:0] PH_SOI1 = 3'd1;
  localparam logic [2:0] PH_MARK = 3'd2;
  localparam logic [2:0] PH_LENH = 3'd3;
  localparam logic [2:0] PH_LENL = 3'd4;
  localparam logic [2:0] PH_BODY = 3'd5;

  // marker bytes
  localparam logic [7:0] MK_FILL = 8'hFF;
  localparam logic [7:0] MK_SOI  = 8'hD8;
  localparam logic [7:0] MK_EOI  = 8'hD9;
  localparam logic [7:0] MK_SOS  = 8'hDA;
  localparam logic [7:0] MK_APP1 = 8'hE1;

  // "Exif" signature at the head of an APP1 body
  function automatic logic [7:0] exif_sig(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h45;
      2'd1:    r = 8'h78;
      2'd2:    r = 8'h69;
      default: r = 8'h66;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[src/jesl_scan.sv]
// Scan state registers and combinational per-byte update of the marker segment walker
`default_nettype none
module jesl_scan
  import jesl_pkg::*;
#(
  parameter int MAX_MARKER_READS = MaxMarkerReads,
  parameter int POSITION_BITS    = PositionBits
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step,
  input  wire item_t   item,
  output logic         res_valid,
  output result_t      res
);

  localparam int FillBits = (MAX_MARKER_READS > 2) ? $clog2(MAX_MARKER_READS) : 1;
  localparam logic [FillBits-1:0] FillLimit = FillBits'(MAX_MARKER_READS - 1);

  // scan state
  logic [2:0]               phase, phase_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [FillBits-1:0]      fill_count, fill_count_next;
  logic [7:0]               marker_code, marker_code_next;
  logic [15:0]              length_value, length_value_next;
  logic [15:0]              bytes_left, bytes_left_next;
  logic [2:0]               signature_matched, signature_matched_next;
  logic [2:0]               body_index, body_index_next;
  logic                     scan_done, scan_done_next;
  logic                     length_known, length_known_next;

  // values seen by this beat, after a restart if one is flagged
  logic [2:0]               ph;
  logic [POSITION_BITS-1:0] pos;
  logic [FillBits-1:0]      fc;
  logic [7:0]               mk;
  logic [15:0]              lv;
  logic [15:0]              bl;
  logic [2:0]               sm;
  logic [2:0]               bi;
  logic                     done;
  logic                     lk;

  logic                     seg_end;
  logic [15:0]              seg_len;
  logic [15:0]              len_full;
  logic [POSITION_BITS-1:0] tiff_pos;
  logic [7:0]               b;

  assign b = item.data_byte;

  // per-byte update
  always_comb begin
    ph   = item.start_of_file ? PH_SOI0 : phase;
    pos  = item.start_of_file ? '0 : byte_position;
    fc   = item.start_of_file ? '0 : fill_count;
    mk   = item.start_of_file ? '0 : marker_code;
    lv   = item.start_of_file ? '0 : length_value;
    bl   = item.start_of_file ? '0 : bytes_left;
    sm   = item.start_of_file ? '0 : signature_matched;
    bi   = item.start_of_file ? '0 : body_index;
    done = item.start_of_file ? 1'b0 : scan_done;
    lk   = item.start_of_file ? 1'b0 : length_known;

    phase_next             = ph;
    byte_position_next     = pos;
    fill_count_next        = fc;
    marker_code_next       = mk;
    length_value_next      = lv;
    bytes_left_next        = bl;
    signature_matched_next = sm;
    body_index_next        = bi;
    length_known_next      = lk;

    res_valid          = 1'b0;
    res.status         = ST_EXIF;
    res.exif_location  = '0;
    res.segment_length = '0;
    seg_end  = 1'b0;
    seg_len  = lv;
    len_full = {lv[15:8], b};
    tiff_pos = '0;

    if (!done) begin
      if (item.end_of_file) begin
        res_valid = 1'b1;
        if (ph == PH_SOI0 || ph == PH_SOI1) begin
          res.status = ST_NOSOI;
        end else begin
          res.status         = ST_PREMATURE;
          res.segment_length = lk ? lv : 16'd0;
        end
      end else begin
        byte_position_next = pos + POSITION_BITS'(1);
        case (ph)
          PH_SOI0: begin
            if (b != MK_FILL) begin
              res_valid  = 1'b1;
              res.status = ST_NOSOI;
            end else begin
              phase_next = PH_SOI1;
            end
          end
          PH_SOI1: begin
            if (b != MK_SOI) begin
              res_valid  = 1'b1;
              res.status = ST_NOSOI;
            end else begin
              phase_next      = PH_MARK;
              fill_count_next = '0;
            end
          end
          PH_MARK: begin
            if (b == MK_FILL) begin
              if (fc >= FillLimit) begin
                res_valid  = 1'b1;
                res.status = ST_FILL;
              end else begin
                fill_count_next = fc + FillBits'(1);
              end
            end else begin
              marker_code_next = b;
              phase_next       = PH_LENH;
            end
          end
          PH_LENH: begin
            length_value_next = {b, 8'h00};
            phase_next        = PH_LENL;
          end
          PH_LENL: begin
            length_value_next = len_full;
            length_known_next = 1'b1;
            if (len_full < 16'd2) begin
              res_valid          = 1'b1;
              res.status         = ST_BADLEN;
              res.segment_length = len_full;
            end else begin
              bytes_left_next        = len_full - 16'd2;
              signature_matched_next = '0;
              body_index_next        = '0;
              seg_len                = len_full;
              if (len_full == 16'd2) begin
                seg_end = 1'b1;
              end else begin
                phase_next = PH_BODY;
              end
            end
          end
          default: begin
            // signature compare on the first four body bytes
            if (bi < 3'd4 && sm == bi && b == exif_sig(bi[1:0])) begin
              signature_matched_next = sm + 3'd1;
            end
            if (bi < 3'd4) begin
              body_index_next = bi + 3'd1;
            end
            bytes_left_next = bl - 16'd1;
            if (bl == 16'd1) begin
              seg_end = 1'b1;
            end
          end
        endcase

        // whole segment taken in
        if (seg_end) begin
          tiff_pos = byte_position_next - POSITION_BITS'(seg_len) + POSITION_BITS'(8);
          if (mk == MK_SOS) begin
            res_valid          = 1'b1;
            res.status         = ST_SOS;
            res.segment_length = seg_len;
          end else if (mk == MK_EOI) begin
            res_valid          = 1'b1;
            res.status         = ST_EOI;
            res.segment_length = seg_len;
          end else if (mk == MK_APP1) begin
            res_valid          = 1'b1;
            res.segment_length = seg_len;
            if (signature_matched_next == 3'd4) begin
              res.status        = ST_EXIF;
              res.exif_location = 32'(tiff_pos);
            end else begin
              res.status = ST_NOTEXIF;
            end
          end else begin
            phase_next        = PH_MARK;
            fill_count_next   = '0;
            length_known_next = 1'b0;
          end
        end
      end
    end
    scan_done_next = done | res_valid;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_SOI0;
      byte_position     <= '0;
      fill_count        <= '0;
      marker_code       <= '0;
      length_value      <= '0;
      bytes_left        <= '0;
      signature_matched <= '0;
      body_index        <= '0;
      scan_done         <= 1'b0;
      length_known      <= 1'b0;
    end else if (step) begin
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      fill_count        <= fill_count_next;
      marker_code       <= marker_code_next;
      length_value      <= length_value_next;
      bytes_left        <= bytes_left_next;
      signature_matched <= signature_matched_next;
      body_index        <= body_index_next;
      scan_done         <= scan_done_next;
      length_known      <= length_known_next;
    end
  end

  // no result once a scan has ended, until restarted
  a_quiet_after_done: assert property (@(posedge clk) disable iff (rst)
    (scan_done && !item.start_of_file) |-> !res_valid)
    else $error("result after scan end");

  // signature count never outruns body index by skipping
  a_sig_bound: assert property (@(posedge clk) disable iff (rst)
    signature_matched <= body_index)
    else $error("signature count exceeds body index");

  // fill count stays below the marker read limit
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FillLimit)
    else $error("fill count over limit");

endmodule
`default_nettype wire

[src/jpeg_exif_segment_locator_unit.sv]
// A byte held in the input register is stepped once the result register is free; the scan state
// then updates once for that byte and any result is loaded into the result register. One byte
// per cycle while the result side does not stall. An input register and a result register part
// the two channels; while a result waits the input register takes one more byte, then the input
// stalls until the result is taken. Reset (rst, synchronous) empties both registers and puts the
// scan at the first SOI byte with position zero; a scan is live right after reset.
`default_nettype none
module jpeg_exif_segment_locator_unit
  import jesl_pkg::*;
#(
  parameter int MAX_MARKER_READS = MaxMarkerReads,
  parameter int POSITION_BITS    = PositionBits
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  logic    in_full;
  item_t   in_item;
  logic    step;
  logic    out_free;
  logic    res_valid;
  result_t res;

  // result register can load when empty or being taken
  assign out_free   = !result_valid || !result_stall;
  assign step       = in_full && out_free;
  assign item_stall = in_full && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!item_stall) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      in_item <= item;
    end
  end

  jesl_scan #(
    .MAX_MARKER_READS (MAX_MARKER_READS),
    .POSITION_BITS    (POSITION_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (in_item),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res_valid) begin
      result <= res;
    end
  end

  // location only reported with an Exif outcome
  a_loc_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_EXIF) |-> result.exif_location == 32'd0)
    else $error("location set without exif");

  // outcomes that precede any length field carry no length
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == ST_NOSOI || result.status == ST_FILL))
      |-> result.segment_length == 16'd0)
    else $error("length set on early outcome");

  // input side only stalls with a byte held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (in_full && result_valid && result_stall))
    else $error("stall without held byte");

endmodule
`default_nettype wire

[bench/jesl_checker.sv]
// Checker for the JPEG Exif locator: mirrors the byte scan and compares every result beat
`timescale 1ns / 100ps
module jesl_checker
  import jesl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  input  wire logic    item_stall,
  input  wire item_t   item,
  input  wire logic    result_valid,
  input  wire logic    result_stall,
  input  wire result_t result,
  output int           fail_count,
  output int           outcomes_due,
  output int           outcomes_checked
);

  localparam logic [31:0] ExifTag  = 32'h4578_6966;
  localparam int          PrintCap = 100;

  // mirrored scan state
  logic [2:0]  scan_phase;
  logic [31:0] file_pos;
  logic [2:0]  fill_seen;
  logic [7:0]  marker;
  logic [15:0] seg_len;
  logic [15:0] body_left;
  logic [2:0]  tag_hits;
  logic        scan_over;
  logic        len_read;

  // scan outcomes still to come out of the block, oldest first
  result_t outcome_q[$];

  task automatic report_mismatch(input string what);
    if (fail_count < PrintCap) $display("%0t ns: mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic restart_scan();
    scan_phase = PH_SOI0;
    file_pos   = '0;
    fill_seen  = '0;
    marker     = '0;
    seg_len    = '0;
    body_left  = '0;
    tag_hits   = '0;
    scan_over  = 1'b0;
    len_read   = 1'b0;
  endtask

  task automatic post_outcome(input logic [2:0] st, input logic [31:0] loc,
                              input logic [15:0] len);
    result_t r;
    r.status         = st;
    r.exif_location  = loc;
    r.segment_length = len;
    outcome_q.push_back(r);
    scan_over = 1'b1;
  endtask

  // last byte of a segment taken in: terminal markers end the scan
  task automatic close_segment();
    if (marker == MK_SOS) begin
      post_outcome(ST_SOS, '0, seg_len);
    end else if (marker == MK_EOI) begin
      post_outcome(ST_EOI, '0, seg_len);
    end else if (marker == MK_APP1) begin
      if (tag_hits == 3'd4) post_outcome(ST_EXIF, file_pos - {16'h0, seg_len} + 32'd8, seg_len);
      else post_outcome(ST_NOTEXIF, '0, seg_len);
    end else begin
      scan_phase = PH_MARK;
      fill_seen  = '0;
      len_read   = 1'b0;
    end
  endtask

  // one accepted input beat through the scan
  task automatic scan_beat(input item_t beat);
    logic [7:0]  b;
    logic [15:0] idx;
    logic [7:0]  tag_byte;
    b = beat.data_byte;
    if (beat.start_of_file) restart_scan();
    if (scan_over) return;
    if (beat.end_of_file) begin
      if (scan_phase == PH_SOI0 || scan_phase == PH_SOI1) post_outcome(ST_NOSOI, '0, '0);
      else post_outcome(ST_PREMATURE, '0, len_read ? seg_len : 16'd0);
      return;
    end
    file_pos = file_pos + 32'd1;
    case (scan_phase)
      PH_SOI0: begin
        if (b != MK_FILL) post_outcome(ST_NOSOI, '0, '0);
        else scan_phase = PH_SOI1;
      end
      PH_SOI1: begin
        if (b != MK_SOI) begin
          post_outcome(ST_NOSOI, '0, '0);
        end else begin
          scan_phase = PH_MARK;
          fill_seen  = '0;
        end
      end
      PH_MARK: begin
        if (b == MK_FILL) begin
          if (int'(fill_seen) + 1 >= MaxMarkerReads) post_outcome(ST_FILL, '0, '0);
          else fill_seen = fill_seen + 3'd1;
        end else begin
          marker     = b;
          scan_phase = PH_LENH;
        end
      end
      PH_LENH: begin
        seg_len    = {b, 8'h00};
        scan_phase = PH_LENL;
      end
      PH_LENL: begin
        seg_len[7:0] = b;
        len_read     = 1'b1;
        if (seg_len < 16'd2) begin
          post_outcome(ST_BADLEN, '0, seg_len);
        end else begin
          body_left = seg_len - 16'd2;
          tag_hits  = '0;
          if (body_left == 16'd0) close_segment();
          else scan_phase = PH_BODY;
        end
      end
      default: begin
        // leading body bytes are matched against the signature in order
        idx      = (seg_len - 16'd2) - body_left;
        tag_byte = ExifTag[8*(3 - idx[1:0]) +: 8];
        if (idx < 16'd4 && {13'h0, tag_hits} == idx && b == tag_byte)
          tag_hits = tag_hits + 3'd1;
        body_left = body_left - 16'd1;
        if (body_left == 16'd0) close_segment();
      end
    endcase
  endtask

  task automatic check_outcome(input result_t got);
    result_t want;
    if (outcome_q.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing due, status %0d", got.status));
      return;
    end
    want = outcome_q.pop_front();
    outcomes_checked++;
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.exif_location !== want.exif_location)
      report_mismatch($sformatf("exif_location %0h, want %0h",
                                got.exif_location, want.exif_location));
    if (got.segment_length !== want.segment_length)
      report_mismatch($sformatf("segment_length %0h, want %0h",
                                got.segment_length, want.segment_length));
  endtask

  // watch both channels on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      restart_scan();
      outcome_q.delete();
      fail_count       = 0;
      outcomes_checked = 0;
    end else begin
      if (result_valid && !result_stall) check_outcome(result);
      if (item_valid && !item_stall) scan_beat(item);
    end
    outcomes_due <= outcome_q.size();
  end

endmodule

[bench/tb_top.sv]
// Testbench top for the JPEG Exif locator: clock, reset, byte stream stimulus and verdict
`timescale 1ns / 100ps
module tb_top;
  import jesl_pkg::*;

  localparam int          CycleLimit  = 1_000_000;
  localparam int          RandomBeats = 850;
  localparam int          DrainCycles = 8;
  localparam logic [31:0] ExifTag     = 32'h4578_6966;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  int fail_count;
  int outcomes_due;
  int outcomes_checked;
  int cycle_count;
  int beats_sent;
  int counted_beats;
  int files_made;
  int cut_left;
  bit steady;
  bit random_phase;
  bit tail_beat;
  bit sof_pending;

  jpeg_exif_segment_locator_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  jesl_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .item             (item),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result           (result),
    .fail_count       (fail_count),
    .outcomes_due     (outcomes_due),
    .outcomes_checked (outcomes_checked)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped at the cycle limit");
    $display("FAIL");
    $finish;
  end

  // result side: random stalls, one long hold-off so the block backs up
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && random_phase && counted_beats >= 200) begin
        hold_left = 500;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= !steady && ($urandom_range(99) < 36);
      end
    end
  end

  // one input beat, held until accepted
  task automatic send_beat(input item_t beat);
    while (!steady && $urandom_range(99) < 36) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= beat;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
    beats_sent++;
    if (!tail_beat) counted_beats++;
  endtask

  // file byte; a running cut count drops the rest of a truncated file
  task automatic put_byte(input logic [7:0] b);
    item_t beat;
    if (cut_left == 0) return;
    if (cut_left > 0) cut_left--;
    beat.data_byte     = b;
    beat.start_of_file = sof_pending;
    beat.end_of_file   = 1'b0;
    sof_pending        = 1'b0;
    send_beat(beat);
  endtask

  task automatic put_eof();
    item_t beat;
    beat.data_byte     = 8'($urandom_range(255));
    beat.start_of_file = sof_pending;
    beat.end_of_file   = 1'b1;
    sof_pending        = 1'b0;
    send_beat(beat);
  endtask

  task automatic start_file(input bit with_sof);
    sof_pending = with_sof;
    put_byte(MK_FILL);
    put_byte(MK_SOI);
  endtask

  // fill bytes, marker, big-endian length, body (optionally headed by the signature)
  task automatic put_segment(input logic [7:0] code, input int fills,
                             input logic [15:0] len, input bit with_tag);
    int i;
    repeat (fills) put_byte(MK_FILL);
    put_byte(code);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
    for (i = 0; i < int'(len) - 2; i++)
      put_byte((with_tag && i < 4) ? ExifTag[8*(3 - i) +: 8] : 8'($urandom_range(255)));
  endtask

  // mostly short segments, a few with a non-zero high length byte
  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'(2 + $urandom_range(10));
    if (r < 95) return 16'(13 + $urandom_range(200));
    return 16'(256 + $urandom_range(700));
  endfunction

  function automatic int pick_fills();
    return ($urandom_range(3) == 0) ? $urandom_range(MaxMarkerReads - 1) : 1;
  endfunction

  function automatic logic [7:0] pick_plain_marker();
    logic [7:0] code;
    code = 8'($urandom_range(255));
    while (code == MK_FILL || code == MK_EOI || code == MK_SOS || code == MK_APP1)
      code = 8'($urandom_range(255));
    return code;
  endfunction

  task automatic directed_files();
    // scan is live straight after reset, no start flag on this file
    start_file(1'b0);
    put_segment(MK_APP1, 1, 16'd16, 1'b1);
    // start and end of file on the same beat
    sof_pending = 1'b1;
    put_eof();
    // end of file inside the SOI check
    sof_pending = 1'b1;
    put_byte(MK_FILL);
    put_eof();
    // wrong first byte, then wrong second byte
    sof_pending = 1'b1;
    put_byte(8'h00);
    sof_pending = 1'b1;
    put_byte(MK_FILL);
    put_byte(MK_FILL);
    // minimum length segments before SOS
    start_file(1'b1);
    put_segment(8'hE0, 1, 16'd2, 1'b0);
    put_segment(MK_SOS, 1, 16'd2, 1'b0);
    // marker with no prefix, then SOS behind two fills
    start_file(1'b1);
    put_segment(8'h00, 0, 16'd3, 1'b0);
    put_segment(MK_SOS, 2, 16'd3, 1'b0);
    // most fill bytes still allowed, then EOI
    start_file(1'b1);
    put_segment(MK_EOI, MaxMarkerReads - 1, 16'd4, 1'b0);
    // one fill byte too many
    start_file(1'b1);
    repeat (MaxMarkerReads) put_byte(MK_FILL);
    // length fields below two
    start_file(1'b1);
    put_segment(8'hC0, 1, 16'd0, 1'b0);
    start_file(1'b1);
    put_segment(8'hC4, 0, 16'd1, 1'b0);
    // empty and short APP1 bodies
    start_file(1'b1);
    put_segment(MK_APP1, 1, 16'd2, 1'b0);
    start_file(1'b1);
    put_segment(MK_APP1, 1, 16'd5, 1'b1);
    // signature broken on its last letter
    start_file(1'b1);
    put_byte(MK_FILL);
    put_byte(MK_APP1);
    put_byte(8'h00);
    put_byte(8'h08);
    put_byte(ExifTag[31:24]);
    put_byte(ExifTag[23:16]);
    put_byte(ExifTag[15:8]);
    put_byte(8'h67);
    put_byte(8'h00);
    put_byte(8'h00);
    // end of file before, inside and after the length field, mid body, between segments
    start_file(1'b1);
    put_byte(MK_FILL);
    put_byte(8'hE0);
    put_eof();
    start_file(1'b1);
    put_byte(MK_FILL);
    put_byte(8'hE0);
    put_byte(8'h00);
    put_eof();
    start_file(1'b1);
    put_byte(MK_FILL);
    put_byte(8'hE0);
    put_byte(8'h00);
    put_byte(8'h08);
    put_byte(8'hAA);
    put_eof();
    start_file(1'b1);
    put_segment(8'hE0, 1, 16'd4, 1'b0);
    put_eof();
    // restart in the middle of a segment body
    start_file(1'b1);
    put_byte(MK_FILL);
    put_byte(8'hE2);
    put_byte(8'h00);
    put_byte(8'h20);
    put_byte(8'h01);
    start_file(1'b1);
    put_segment(MK_EOI, 1, 16'd2, 1'b0);
    // beats after an outcome are dropped until the next start
    put_byte(MK_FILL);
    put_byte(MK_SOI);
    put_eof();
    // skipped segment, then an APP1 with a non-zero high length byte carrying the signature
    start_file(1'b1);
    put_segment(8'hE0, 1, 16'd20, 1'b0);
    put_segment(MK_APP1, 1, 16'h0104, 1'b1);
  endtask

  // one random file: mostly well formed, some noise, cut or broken
  task automatic random_file();
    int          kind;
    int          ending;
    logic [15:0] len;
    kind     = $urandom_range(99);
    cut_left = -1;
    if (kind < 8) begin
      // noise, with or without a start flag
      sof_pending = $urandom_range(3) != 0;
      repeat ($urandom_range(1, 12))
        put_byte($urandom_range(1) ? MK_FILL : 8'($urandom_range(255)));
      if ($urandom_range(1)) put_eof();
    end else begin
      if (kind < 20) cut_left = $urandom_range(40);
      start_file(1'b1);
      repeat ($urandom_range(3)) put_segment(pick_plain_marker(), pick_fills(), pick_len(), 1'b0);
      ending = $urandom_range(99);
      if (ending < 35) begin
        len = pick_len();
        if (len < 16'd6) len = 16'd6;
        put_segment(MK_APP1, pick_fills(), len, 1'b1);
      end else if (ending < 45) begin
        len = $urandom_range(1) ? 16'(2 + $urandom_range(3)) : pick_len();
        put_segment(MK_APP1, pick_fills(), len, len < 16'd6);
      end else if (ending < 60) begin
        put_segment(MK_SOS, pick_fills(), pick_len(), 1'b0);
      end else if (ending < 72) begin
        put_segment(MK_EOI, pick_fills(), pick_len(), 1'b0);
      end else if (ending < 80) begin
        repeat (pick_fills()) put_byte(MK_FILL);
        put_byte(8'($urandom_range(254)));
        put_byte(8'h00);
        put_byte(8'($urandom_range(1)));
      end else if (ending < 88) begin
        repeat (MaxMarkerReads) put_byte(MK_FILL);
      end else begin
        put_eof();
      end
      // cut files mostly end in an end of file, the rest are left for the next start
      if (cut_left >= 0 && kind < 16) put_eof();
      cut_left = -1;
    end
    // trailing beats the block should ignore
    if ($urandom_range(5) == 0) begin
      tail_beat = 1'b1;
      repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(255)));
      if ($urandom_range(1)) put_eof();
      tail_beat = 1'b0;
    end
  endtask

  initial begin : stimulus
    item_valid    = 1'b0;
    item          = '0;
    rst           = 1'b1;
    steady        = 1'b0;
    random_phase  = 1'b0;
    tail_beat     = 1'b0;
    sof_pending   = 1'b0;
    cut_left      = -1;
    beats_sent    = 0;
    counted_beats = 0;
    files_made    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_files();

    counted_beats = 0;
    random_phase  = 1'b1;
    while (counted_beats < RandomBeats) begin
      steady = counted_beats >= 500 && counted_beats < 800;
      random_file();
      files_made++;
    end
    steady = 1'b0;
    item_valid <= 1'b0;

    // drain outstanding outcomes, then keep watching for strays
    while (outcomes_due != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d input beats, %0d of them over %0d random files",
             beats_sent, counted_beats, files_made);
    $display("%0d scan outcomes compared, %0d mismatches", outcomes_checked, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
